[hw/rtl/bmp_pixel_stream_unpacker_top_defines.svh]
// ----------------------------------------------------------------------------
// bmp pixel stream unpacker assertion macros
// shared concurrent assertion forms, clocked on clk; the first is disabled in reset arst_n
// ----------------------------------------------------------------------------
`ifndef BMP_PIXEL_STREAM_UNPACKER_TOP_DEFINES_SVH
`define BMP_PIXEL_STREAM_UNPACKER_TOP_DEFINES_SVH

// checked only outside reset
`define BPSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BPSU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bpsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsu_pkg
// constants, codes, types and helpers of the bmp pixel stream unpacker
// ----------------------------------------------------------------------------
package bpsu_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int NG_CNT_W        = PAL_AW + 1;
	localparam int MAX_SIDE        = 4096;
	localparam int SIDE_W          = $clog2(MAX_SIDE) + 1;
	localparam int POS_W           = $clog2(MAX_SIDE);
	localparam int OFF_W           = 26;
	localparam int CFG_W           = 13;
	localparam int REG_IDX_W       = 2;
	localparam int FMT_W           = 2;
	localparam int CMD_W           = 2;

	// commands
	localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PAL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

	// source formats
	localparam logic [FMT_W-1:0] FMT_PAL8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB24 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_RGB32 = 2'd2;
	localparam logic [FMT_W-1:0] FMT_RSVD  = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd2;

	typedef struct packed {
		logic       nongray;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pal_entry_t;

	// zero counts as one, oversize counts as the maximum
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

endpackage

[hw/rtl/bpsu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsu channel interfaces
// valid/ready request channels for input items and pixel results
// ----------------------------------------------------------------------------
interface bpsu_in_if import bpsu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [7:0]       data_byte;
	logic [7:0]       palette_index;
	logic [7:0]       palette_blue;
	logic [7:0]       palette_green;
	logic [7:0]       palette_red;

	modport source (
		output valid, command, data_byte, palette_index,
		       palette_blue, palette_green, palette_red,
		input  ready
	);
	modport sink (
		input  valid, command, data_byte, palette_index,
		       palette_blue, palette_green, palette_red,
		output ready
	);
endinterface

interface bpsu_out_if import bpsu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] dest_offset;
	logic [7:0]       blue;
	logic [7:0]       green;
	logic [7:0]       red;
	logic             gray_format;
	logic             frame_done;

	modport source (
		output valid, dest_offset, blue, green, red, gray_format, frame_done,
		input  ready
	);
	modport sink (
		input  valid, dest_offset, blue, green, red, gray_format, frame_done,
		output ready
	);
endinterface

[hw/rtl/bmp_pixel_stream_unpacker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp pixel stream unpacker
// unpacks bmp pixel-data bytes into pixels with top-down byte offsets
// ----------------------------------------------------------------------------
//
//  channel    dir  carries
//  ---------  ---  ------------------------------------------------------
//  pixel_in   in   command, data byte, palette index and color
//  pixel_out  out  dest offset, color, gray flag, last-pixel flag
//  wr_*       in   register writes: width, height, source format
//
//  one request per cycle sustained unless the output stalls; a pixel passes
//  the accept stage (palette read), then the update stage, into the output
//  the palette memory is read on accept and written in the update
//  stage; a write to the entry read in the same cycle is forwarded
//  reset clears the palette at once through per-entry valid flags
//  a full, untaken output register stalls only pixel-finishing requests
//
module bmp_pixel_stream_unpacker_top import bpsu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	bpsu_in_if.sink              pixel_in,
	bpsu_out_if.source           pixel_out
);

	// configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [FMT_W-1:0] format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			format_q <= FMT_RGB24;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				REG_FORMAT: format_q <= wr_data[FMT_W-1:0];
				default:    ;
			endcase
		end
	end

	logic [SIDE_W-1:0] w_cl;
	logic [SIDE_W-1:0] h_cl;
	logic [FMT_W-1:0]  fmt_eff;

	assign w_cl    = clamp_side(width_q);
	assign h_cl    = clamp_side(height_q);
	// reserved format code behaves as 24-bit
	assign fmt_eff = (format_q == FMT_RSVD) ? FMT_RGB24 : format_q;

	// (height-1)*width, registered off the config so frame starts stay short
	logic [2*SIDE_W-1:0] prod_full;
	logic [OFF_W-1:0]    prod_q;

	assign prod_full = (2*SIDE_W)'(h_cl - SIDE_W'(1)) * (2*SIDE_W)'(w_cl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else begin
			prod_q <= prod_full[OFF_W-1:0];
		end
	end

	function automatic logic [OFF_W-1:0] frame_base(input logic g, input logic [OFF_W-1:0] p);
		logic [OFF_W-1:0] r;
		r = g ? p : p + {p[OFF_W-2:0], 1'b0};
		return r;
	endfunction

	// accept stage: palette read issued with the request
	logic             in_acc;
	logic             s1_go;
	logic [7:0]       rd_idx;
	logic             s1_valid_q;
	logic [CMD_W-1:0] cmd_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       pidx_s1;
	logic [7:0]       pblue_s1;
	logic [7:0]       pgreen_s1;
	logic [7:0]       pred_s1;

	assign in_acc         = pixel_in.valid && pixel_in.ready;
	assign pixel_in.ready = !s1_valid_q || s1_go;
	assign rd_idx         = (pixel_in.command == CMD_PAL) ? pixel_in.palette_index
	                                                      : pixel_in.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= pixel_in.command;
			byte_s1   <= pixel_in.data_byte;
			pidx_s1   <= pixel_in.palette_index;
			pblue_s1  <= pixel_in.palette_blue;
			pgreen_s1 <= pixel_in.palette_green;
			pred_s1   <= pixel_in.palette_red;
		end
	end

	// palette memory, valid flags and write forwarding
	pal_entry_t                 pal_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;
	pal_entry_t                 rd_data_s1;
	logic                       rd_vld_s1;
	logic                       fwd_hit_s1;
	pal_entry_t                 fwd_data_s1;
	logic                       pal_we;
	pal_entry_t                 wr_entry;

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pidx_s1[PAL_AW-1:0]] <= wr_entry;
		end
		if (in_acc) begin
			rd_data_s1  <= pal_mem[rd_idx[PAL_AW-1:0]];
			fwd_data_s1 <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (pal_we) begin
				pal_vld_q[pidx_s1[PAL_AW-1:0]] <= 1'b1;
			end
			if (in_acc) begin
				rd_vld_s1  <= pal_vld_q[rd_idx[PAL_AW-1:0]];
				// read and write of one entry at the same edge: read saw old data
				fwd_hit_s1 <= pal_we && (pidx_s1 == rd_idx);
			end
		end
	end

	pal_entry_t ent;
	pal_entry_t ent_sel;
	logic       pidx_ok;

	assign ent     = fwd_hit_s1 ? fwd_data_s1 : (rd_vld_s1 ? rd_data_s1 : '0);
	// out-of-range index reads as black
	assign ent_sel = (32'(byte_s1) < PALETTE_ENTRIES) ? ent : '0;
	assign pidx_ok = 32'(pidx_s1) < PALETTE_ENTRIES;

	always_comb begin
		wr_entry.blue    = pblue_s1;
		wr_entry.green   = pgreen_s1;
		wr_entry.red     = pred_s1;
		wr_entry.nongray = (pblue_s1 != pgreen_s1) || (pblue_s1 != pred_s1);
	end

	// update stage state
	logic [NG_CNT_W-1:0] ng_cnt_q;
	logic                gray_q;
	logic [POS_W-1:0]    col_q;
	logic [POS_W-1:0]    row_q;
	logic [1:0]          bip_q;
	logic [1:0]          pad_q;
	logic [23:0]         part_q;
	logic [OFF_W-1:0]    rbase_q;

	logic             gray_now;
	logic             gray_new;
	logic [2:0]       need;
	logic             gather;
	logic             has_result;
	logic             out_free;
	logic             load;
	logic [SIDE_W-1:0] col_next;
	logic [SIDE_W-1:0] row_next;
	logic             row_end;
	logic             frame_end;
	logic [OFF_W-1:0] w_off;
	logic [OFF_W-1:0] col_off;
	logic [OFF_W-1:0] wbpp;
	logic [OFF_W-1:0] offset;
	logic [1:0]       rb_lo;
	logic [1:0]       pad_new;
	logic [7:0]       px_b;
	logic [7:0]       px_g;
	logic [7:0]       px_r;

	assign gray_now   = gray_q && (fmt_eff == FMT_PAL8);
	assign gray_new   = (ng_cnt_q == '0);
	assign need       = (fmt_eff == FMT_PAL8) ? 3'd1 : ((fmt_eff == FMT_RGB24) ? 3'd3 : 3'd4);
	assign gather     = (({1'b0, bip_q} + 3'd1) < need);
	assign has_result = (cmd_s1 == CMD_PIXEL) && (pad_q == 2'd0) && !gather;
	assign out_free   = !pixel_out.valid || pixel_out.ready;
	assign s1_go      = s1_valid_q && (!has_result || out_free);
	assign load       = s1_go && has_result;
	assign pal_we     = s1_go && (cmd_s1 == CMD_PAL) && pidx_ok;

	assign col_next  = {1'b0, col_q} + SIDE_W'(1);
	assign row_next  = {1'b0, row_q} + SIDE_W'(1);
	assign row_end   = col_next >= w_cl;
	assign frame_end = row_next >= h_cl;

	assign w_off   = OFF_W'(w_cl);
	assign col_off = OFF_W'(col_q);
	assign wbpp    = gray_now ? w_off : w_off + {w_off[OFF_W-2:0], 1'b0};
	assign offset  = rbase_q + (gray_now ? col_off : col_off + {col_off[OFF_W-2:0], 1'b0});

	// source row length mod 4 gives the padding
	always_comb begin
		case (fmt_eff)
			FMT_PAL8:  rb_lo = w_cl[1:0];
			FMT_RGB24: rb_lo = w_cl[1:0] + {w_cl[0], 1'b0};
			default:   rb_lo = 2'd0;
		endcase
	end
	assign pad_new = 2'd0 - rb_lo;

	always_comb begin
		if (fmt_eff == FMT_PAL8) begin
			px_b = ent_sel.blue;
			px_g = ent_sel.green;
			px_r = ent_sel.red;
		end else begin
			px_b = part_q[7:0];
			px_g = part_q[15:8];
			px_r = (fmt_eff == FMT_RGB24) ? byte_s1 : part_q[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ng_cnt_q <= '0;
			gray_q   <= 1'b1;
			col_q    <= '0;
			row_q    <= '0;
			bip_q    <= '0;
			pad_q    <= '0;
			part_q   <= '0;
			rbase_q  <= '0;
		end else if (s1_go) begin
			case (cmd_s1)
				CMD_PAL: begin
					if (pidx_ok) begin
						ng_cnt_q <= ng_cnt_q - NG_CNT_W'(ent.nongray)
						            + NG_CNT_W'(wr_entry.nongray);
					end
				end
				CMD_FRAME: begin
					gray_q  <= gray_new;
					col_q   <= '0;
					row_q   <= '0;
					bip_q   <= '0;
					pad_q   <= '0;
					part_q  <= '0;
					rbase_q <= frame_base(gray_new && (fmt_eff == FMT_PAL8), prod_q);
				end
				CMD_PIXEL: begin
					if (pad_q != 2'd0) begin
						pad_q <= pad_q - 2'd1;
					end else if (gather) begin
						// fourth byte of a 32-bit pixel is dropped
						if (bip_q != 2'd3) begin
							part_q <= part_q | (24'(byte_s1) << {bip_q, 3'b000});
						end
						bip_q <= bip_q + 2'd1;
					end else begin
						bip_q  <= '0;
						part_q <= '0;
						if (row_end) begin
							col_q <= '0;
							pad_q <= pad_new;
							if (frame_end) begin
								// next image starts, gray choice kept
								row_q   <= '0;
								rbase_q <= frame_base(gray_now, prod_q);
							end else begin
								row_q   <= row_next[POS_W-1:0];
								rbase_q <= rbase_q - wbpp;
							end
						end else begin
							col_q <= col_next[POS_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	logic             out_valid_q;
	logic [OFF_W-1:0] dest_offset_q;
	logic [7:0]       blue_q;
	logic [7:0]       green_q;
	logic [7:0]       red_q;
	logic             gray_format_q;
	logic             frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pixel_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dest_offset_q <= offset;
			blue_q        <= px_b;
			green_q       <= gray_now ? 8'd0 : px_g;
			red_q         <= gray_now ? 8'd0 : px_r;
			gray_format_q <= gray_now;
			frame_done_q  <= row_end && frame_end;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.dest_offset = dest_offset_q;
	assign pixel_out.blue        = blue_q;
	assign pixel_out.green       = green_q;
	assign pixel_out.red         = red_q;
	assign pixel_out.gray_format = gray_format_q;
	assign pixel_out.frame_done  = frame_done_q;

endmodule

[hw/rtl/bpsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsu_checker
// port-level assertions for the bmp pixel stream unpacker
// ----------------------------------------------------------------------------
`include "bmp_pixel_stream_unpacker_top_defines.svh"

module bpsu_checker import bpsu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OFF_W-1:0] dest_offset,
	input logic [7:0]       green,
	input logic [7:0]       red,
	input logic             gray_format,
	input logic             frame_done
);

	// held result stays up
	`BPSU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// held result keeps its position
	`BPSU_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(dest_offset) && $stable(frame_done), "result changed while stalled")

	// a fresh result comes from an accepted request
	`BPSU_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without request")

	// gray pixels carry one byte only
	`BPSU_ASSERT_ALWAYS(a_gray_zero, out_valid && gray_format |-> green == 8'd0 && red == 8'd0, "gray pixel with color")

endmodule

bind bmp_pixel_stream_unpacker_top bpsu_checker u_bpsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixel_in.valid),
	.in_ready    (pixel_in.ready),
	.out_valid   (pixel_out.valid),
	.out_ready   (pixel_out.ready),
	.dest_offset (pixel_out.dest_offset),
	.green       (pixel_out.green),
	.red         (pixel_out.red),
	.gray_format (pixel_out.gray_format),
	.frame_done  (pixel_out.frame_done)
);
